// ----- hdl/uu_xx_line_encoder_assert.svh -----
// Assertion macros for the line encoder, empty when built for synthesis.
`ifndef UU_XX_LINE_ENCODER_ASSERT_SVH
`define UU_XX_LINE_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define UXLE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uu_xx_line_encoder: same-cycle check failed");
// Check cons in the cycle after ante.
`define UXLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uu_xx_line_encoder: next-cycle check failed");
`else
`define UXLE_ASSERT_SAME(label, clk, rst, ante, cons)
`define UXLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/uxle_pkg.sv -----
// Types, constants and character functions shared by the line encoder files.
package uxle_pkg;

   localparam int MAX_LINE_CHARS = 88;
   localparam int CHARS          = 17;   // most characters one word can cause
   localparam int POS_W          = 5;    // holds 0 .. CHARS

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam int UU_TRAILER_LEN = 8;
   localparam int XX_TRAILER_LEN = 5;

   localparam logic [0:UU_TRAILER_LEN-1][7:0] UU_TRAILER =
      {8'h60, 8'h0D, 8'h0A, 8'h65, 8'h6E, 8'h64, 8'h0D, 8'h0A};
   localparam logic [0:XX_TRAILER_LEN-1][7:0] XX_TRAILER =
      {8'h65, 8'h6E, 8'h64, 8'h0D, 8'h0A};

   localparam logic [0:63][7:0] XX_TABLE =
      "+-0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

   typedef enum logic {
      OP_START = 1'b0,
      OP_DATA  = 1'b1
   } op_type;

   typedef enum logic {
      MODE_UU = 1'b0,
      MODE_XX = 1'b1
   } mode_type;

   typedef enum logic {
      CSR_BYTES_PER_LINE = 1'b0,
      CSR_ENCODING_MODE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [5:0] bytes_per_line;
      logic [6:0] enc_len;          // floor(4 * bytes_per_line / 3)
      mode_type   mode;
   } cfg_type;

   typedef struct packed {
      logic [31:0] bytes_remaining;
      logic [6:0]  line_fill;
      logic        trailer_pending;
   } state_type;

   typedef struct packed {
      logic [CHARS-1:0][7:0] chars;   // entry 0 goes out first
      logic [POS_W-1:0]      count;
   } burst_type;

   // Map a 6-bit value to its character in the selected alphabet.
   function automatic logic [7:0] code_char(mode_type mode, logic [5:0] v);
      logic [5:0] dec;
      dec = v - 6'd1;
      if (mode == MODE_XX) begin
         return XX_TABLE[v];
      end
      return {2'b00, dec} + 8'h21;
   endfunction

endpackage

// ----- hdl/uxle_req_if.sv -----
// Request channel of the line encoder: control words and data groups.
interface uxle_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] total_length;
   logic [23:0] group_bytes;
   logic        final_part;

   modport source (output valid, op, total_length, group_bytes, final_part, input ready);
   modport sink   (input valid, op, total_length, group_bytes, final_part, output ready);
endinterface

// ----- hdl/uxle_rsp_if.sv -----
// Response channel of the line encoder: one encoded character per word.
interface uxle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;

   modport source (output valid, out_char, run_last, input ready);
   modport sink   (input valid, out_char, run_last, output ready);
endinterface

// ----- hdl/uxle_encode.sv -----
// Builds every character of one request word and the next encoder state.
module uxle_encode (
   input  uxle_pkg::op_type    op,
   input  logic [31:0]         total_length,
   input  logic [23:0]         group_bytes,
   input  logic                final_part,
   input  uxle_pkg::state_type cur,
   input  uxle_pkg::cfg_type   cfg,
   output uxle_pkg::state_type nxt,
   output uxle_pkg::burst_type burst
);

   logic [uxle_pkg::CHARS-1:0][7:0] chars;
   logic [uxle_pkg::POS_W-1:0]      pos;
   logic [7:0]                      fill_plus4;
   logic                            line_break;
   logic [31:0]                     line_bytes;
   logic [1:0]                      group_n;
   logic [15:0]                     tail_bits;
   logic [31:0]                     rem_after;
   logic                            emit_trailer;

   always_comb begin
      nxt          = cur;
      chars        = '0;
      pos          = '0;
      emit_trailer = 1'b0;

      fill_plus4 = {1'b0, cur.line_fill} + 8'd4;
      line_break = (cur.line_fill > cfg.enc_len) ||
                   (fill_plus4 > 8'(uxle_pkg::MAX_LINE_CHARS));
      line_bytes = (cur.bytes_remaining < {26'd0, cfg.bytes_per_line}) ?
                   cur.bytes_remaining : {26'd0, cfg.bytes_per_line};
      group_n    = (cur.bytes_remaining >= 32'd3) ? 2'd3 : cur.bytes_remaining[1:0];
      // drop unused tail bytes so stray low bits never leak into the code
      tail_bits  = (group_n == 2'd1) ? {group_bytes[23:16], 8'h00} : group_bytes[23:8];
      rem_after  = cur.bytes_remaining - {30'd0, group_n};

      if (op == uxle_pkg::OP_START) begin
         nxt.bytes_remaining = total_length;
         nxt.line_fill       = '0;
         nxt.trailer_pending = final_part;
         emit_trailer        = (total_length == 32'd0) && final_part;
      end else if (cur.bytes_remaining != 32'd0) begin
         if (line_break) begin
            chars[pos]    = uxle_pkg::CHAR_CR;
            pos           = pos + uxle_pkg::POS_W'(1);
            chars[pos]    = uxle_pkg::CHAR_LF;
            pos           = pos + uxle_pkg::POS_W'(1);
            nxt.line_fill = '0;
         end
         if (nxt.line_fill == 7'd0) begin
            chars[pos]    = uxle_pkg::code_char(cfg.mode, line_bytes[5:0]);
            pos           = pos + uxle_pkg::POS_W'(1);
            nxt.line_fill = 7'd1;
         end
         if (group_n == 2'd3) begin
            chars[pos]    = uxle_pkg::code_char(cfg.mode, group_bytes[23:18]);
            pos           = pos + uxle_pkg::POS_W'(1);
            chars[pos]    = uxle_pkg::code_char(cfg.mode, group_bytes[17:12]);
            pos           = pos + uxle_pkg::POS_W'(1);
            chars[pos]    = uxle_pkg::code_char(cfg.mode, group_bytes[11:6]);
            pos           = pos + uxle_pkg::POS_W'(1);
            chars[pos]    = uxle_pkg::code_char(cfg.mode, group_bytes[5:0]);
            pos           = pos + uxle_pkg::POS_W'(1);
            nxt.line_fill = nxt.line_fill + 7'd4;
         end else begin
            chars[pos]    = uxle_pkg::code_char(cfg.mode, tail_bits[15:10]);
            pos           = pos + uxle_pkg::POS_W'(1);
            chars[pos]    = uxle_pkg::code_char(cfg.mode, tail_bits[9:4]);
            pos           = pos + uxle_pkg::POS_W'(1);
            nxt.line_fill = nxt.line_fill + 7'd2;
            if (group_n == 2'd2) begin
               chars[pos]    = uxle_pkg::code_char(cfg.mode, {tail_bits[3:0], 2'b00});
               pos           = pos + uxle_pkg::POS_W'(1);
               nxt.line_fill = nxt.line_fill + 7'd1;
            end
         end
         nxt.bytes_remaining = rem_after;
         if (rem_after == 32'd0) begin
            chars[pos]          = uxle_pkg::CHAR_CR;
            pos                 = pos + uxle_pkg::POS_W'(1);
            chars[pos]          = uxle_pkg::CHAR_LF;
            pos                 = pos + uxle_pkg::POS_W'(1);
            nxt.line_fill       = '0;
            emit_trailer        = cur.trailer_pending;
            nxt.trailer_pending = 1'b0;
         end
      end

      if (emit_trailer) begin
         if (cfg.mode == uxle_pkg::MODE_XX) begin
            for (int i = 0; i < uxle_pkg::XX_TRAILER_LEN; i++) begin
               chars[pos] = uxle_pkg::XX_TRAILER[i];
               pos        = pos + uxle_pkg::POS_W'(1);
            end
         end else begin
            for (int i = 0; i < uxle_pkg::UU_TRAILER_LEN; i++) begin
               chars[pos] = uxle_pkg::UU_TRAILER[i];
               pos        = pos + uxle_pkg::POS_W'(1);
            end
         end
      end

      burst.chars = chars;
      burst.count = pos;
   end

endmodule

// ----- hdl/uxle_drain.sv -----
// Character buffer that shifts one encoded character per response word.
module uxle_drain (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  uxle_pkg::burst_type burst,
   output logic                can_load,
   uxle_rsp_if.source          rsp
);

   logic [uxle_pkg::CHARS-1:0][7:0] chars_ff, chars_in;
   logic [uxle_pkg::POS_W-1:0]      count_ff, count_in;
   logic                            take;

   assign take     = rsp.valid && rsp.ready;
   // empty, or the last character leaves this cycle
   assign can_load = (count_ff == '0) ||
                     ((count_ff == uxle_pkg::POS_W'(1)) && rsp.ready);

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      if (load) begin
         chars_in = burst.chars;
         count_in = burst.count;
      end else if (take) begin
         chars_in = chars_ff >> 8;
         count_in = count_ff - uxle_pkg::POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp.valid    = (count_ff != '0);
   assign rsp.out_char = chars_ff[0];
   assign rsp.run_last = (count_ff == uxle_pkg::POS_W'(1));

endmodule

// ----- hdl/uu_xx_line_encoder.sv -----
// Line encoder top level: uuencode / xxencode body lines from three-byte groups.
// A start word loads the file length and the final-part flag; each data word
// then carries one three-byte group and yields its characters on rsp, one
// character per word, with run_last marking the last character of that request.
// A data group gives four code characters in the common case, plus the length
// character at a line start and CR LF at a line break; the final group adds
// CR LF and, for a final part, the trailer, so one request gives at most 17
// characters. Requests that produce nothing (a start without trailer, data after
// the file is done) pass at one per cycle while the buffer is empty. The rate is
// set by the single response port draining a 17-entry character buffer: a request
// sits in the input register while the buffer empties, and moves in on the same
// cycle the last character is taken, so rsp streams without gaps. Write
// bytes_per_line and encoding_mode only while the block is idle.
`include "uu_xx_line_encoder_assert.svh"

module uu_xx_line_encoder (
   input  logic       clock,
   input  logic       reset,
   uxle_req_if.sink   req,
   uxle_rsp_if.source rsp,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata
);

   // configuration
   logic [5:0]         bpl_ff;
   logic [6:0]         enc_len_ff, enc_len_in;
   uxle_pkg::mode_type mode_ff;
   logic [15:0]        enc_len_prod;
   uxle_pkg::cfg_type  cfg;

   // input register
   logic             in_valid_ff, in_valid_in;
   uxle_pkg::op_type in_op_ff;
   logic [31:0]      in_total_ff;
   logic [23:0]      in_group_ff;
   logic             in_final_ff;

   // encoder state and the character burst for the held request
   uxle_pkg::state_type state_ff, state_in;
   uxle_pkg::burst_type burst;
   logic                can_load;
   logic                commit;

   // floor(x / 3) for x below 256 is (x * 171) >> 9
   assign enc_len_prod = {8'd0, csr_wdata, 2'b00} * 16'd171;
   assign enc_len_in   = enc_len_prod[15:9];

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff     <= 6'd45;
         enc_len_ff <= 7'd60;
         mode_ff    <= uxle_pkg::MODE_UU;
      end else if (csr_we) begin
         unique case (uxle_pkg::csr_index_type'(csr_index))
            uxle_pkg::CSR_BYTES_PER_LINE: begin
               bpl_ff     <= csr_wdata;
               enc_len_ff <= enc_len_in;
            end
            uxle_pkg::CSR_ENCODING_MODE: begin
               mode_ff <= uxle_pkg::mode_type'(csr_wdata[0]);
            end
         endcase
      end
   end

   assign cfg.bytes_per_line = bpl_ff;
   assign cfg.enc_len        = enc_len_ff;
   assign cfg.mode           = mode_ff;

   // Hold a request until the character buffer can take its whole burst;
   // advance it on the cycle the buffer frees up.
   assign commit    = in_valid_ff && can_load;
   assign req.ready = !in_valid_ff || can_load;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end else if (commit) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff    <= uxle_pkg::op_type'(req.op);
         in_total_ff <= req.total_length;
         in_group_ff <= req.group_bytes;
         in_final_ff <= req.final_part;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   uxle_encode u_encode (
      .op           (in_op_ff),
      .total_length (in_total_ff),
      .group_bytes  (in_group_ff),
      .final_part   (in_final_ff),
      .cur          (state_ff),
      .cfg          (cfg),
      .nxt          (state_in),
      .burst        (burst)
   );

   // state moves only when the request's characters enter the buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (commit) begin
         state_ff <= state_in;
      end
   end

   uxle_drain u_drain (
      .clock    (clock),
      .reset    (reset),
      .load     (commit),
      .burst    (burst),
      .can_load (can_load),
      .rsp      (rsp)
   );

   // data after the end of the file produces nothing
   `UXLE_ASSERT_SAME(a_idle_data_silent, clock, reset, commit && (in_op_ff == uxle_pkg::OP_DATA) && (state_ff.bytes_remaining == 32'd0), burst.count == '0)
   // a non-empty burst shows up on rsp the next cycle
   `UXLE_ASSERT_NEXT(a_burst_reaches_rsp, clock, reset, commit && (burst.count != '0), rsp.valid)
   // every encoded group shrinks the remaining byte count
   `UXLE_ASSERT_NEXT(a_remaining_drops, clock, reset, commit && (in_op_ff == uxle_pkg::OP_DATA) && (state_ff.bytes_remaining != 32'd0), state_ff.bytes_remaining < $past(state_ff.bytes_remaining))
   // the line break rule keeps every line within its maximum length
   `UXLE_ASSERT_SAME(a_line_bounded, clock, reset, 1'b1, state_ff.line_fill <= 7'(uxle_pkg::MAX_LINE_CHARS))

endmodule
